FILE: sv/tfp_pkg.sv
// shared types, constants and helpers for the minor frame parity and subcom demux
`timescale 1ns / 1ps
`default_nettype none
package tfp_pkg;

  localparam logic [6:0] FRAME_LEN        = 7'd104;
  localparam logic [6:0] PARITY_POS       = 7'd103;
  localparam logic [6:0] FIRST_GROUP_POS  = 7'd2;
  localparam logic [6:0] GROUP_LEN        = 7'd17;
  localparam logic [6:0] LAST_GROUP_FIRST = 7'd87;
  localparam logic [6:0] FNUM_HI_POS      = 7'd4;
  localparam logic [6:0] FNUM_LO_POS      = 7'd5;
  localparam logic [6:0] SUBCOM_FIRST     = 7'd8;
  localparam logic [6:0] SUBCOM_LAST      = 7'd15;
  localparam logic [8:0] FRAME_MAX        = 9'd319;
  localparam logic [8:0] HALF_ROW         = 9'd160;
  localparam logic [15:0] COUNT_MAX       = 16'hFFFF;
  localparam logic [16:0] RECIP10         = 17'd205;
  localparam int          RECIP10_SHIFT   = 11;
  localparam logic [5:0]  TEN             = 6'd10;

  localparam logic [2:0] CH_ANALOG32S   = 3'd0;
  localparam logic [2:0] CH_ANALOG16S   = 3'd1;
  localparam logic [2:0] CH_ANALOG1S    = 3'd2;
  localparam logic [2:0] CH_ANALOG16S_B = 3'd3;
  localparam logic [2:0] CH_DIGITAL1    = 3'd4;
  localparam logic [2:0] CH_DIGITAL2    = 3'd5;
  localparam logic [2:0] CH_DAU1        = 3'd6;
  localparam logic [2:0] CH_DAU2        = 3'd7;

  typedef struct packed {
    logic [8:0]      frame_number;
    logic            frame_good;
    logic [15:0]     good_count;
    logic [7:0][7:0] subcom;
  } frame_desc_t;

  // subcom byte (offset from byte 8) carried by each channel
  function automatic logic [2:0] subcom_index(input logic [2:0] ch);
    logic [2:0] r;
    case (ch)
      CH_ANALOG32S:   r = 3'd1;
      CH_ANALOG16S:   r = 3'd2;
      CH_ANALOG1S:    r = 3'd3;
      CH_ANALOG16S_B: r = 3'd5;
      CH_DIGITAL1:    r = 3'd0;
      CH_DIGITAL2:    r = 3'd4;
      CH_DAU1:        r = 3'd6;
      CH_DAU2:        r = 3'd7;
      default:        r = 3'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/tfp_front.sv
// front end: byte position tracking, parity accumulation and frame descriptor capture
`timescale 1ns / 1ps
`default_nettype none
module tfp_front import tfp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        parity_check_enable_we,
  input  wire logic        parity_check_enable,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  frame_byte,
  input  wire logic        frame_start,
  input  wire logic        q_full,
  output logic             q_push,
  output frame_desc_t      q_desc
);

  logic [6:0]      pos;
  logic [5:0]      acc;
  logic [8:0]      fnum;
  logic [7:0][7:0] subcom;
  logic [15:0]     gcnt;
  logic            check_en;

  logic        accept, take;
  logic [6:0]  p;
  logic        odd, odd_hi;
  logic [5:0]  acc_base, contrib, acc_next, acc_fin, pbits;
  logic        good;
  logic [15:0] gcnt_next;

  assign full   = q_full;
  assign accept = push && !full;
  assign p      = frame_start ? 7'd0 : pos;
  assign take   = accept && (frame_start || pos < FRAME_LEN);
  assign odd    = ^frame_byte;
  assign odd_hi = ^frame_byte[7:1];

  always_comb begin
    contrib = 6'd0;
    if (p >= FIRST_GROUP_POS && p < LAST_GROUP_FIRST) begin
      if (p < FIRST_GROUP_POS + GROUP_LEN)             contrib[0] = odd;
      else if (p < FIRST_GROUP_POS + 7'd2 * GROUP_LEN) contrib[1] = odd;
      else if (p < FIRST_GROUP_POS + 7'd3 * GROUP_LEN) contrib[2] = odd;
      else if (p < FIRST_GROUP_POS + 7'd4 * GROUP_LEN) contrib[3] = odd;
      else                                             contrib[4] = odd;
    end else if (p >= LAST_GROUP_FIRST && p < PARITY_POS) begin
      contrib[5] = odd;
    end
  end

  assign acc_base = (p == 7'd0) ? 6'd0 : acc;
  assign acc_next = acc_base ^ contrib;
  assign acc_fin  = acc_base ^ {odd_hi, 5'd0};
  // group i is checked against bit 5-i of the parity byte
  assign pbits    = {frame_byte[0], frame_byte[1], frame_byte[2],
                     frame_byte[3], frame_byte[4], frame_byte[5]};
  assign good     = !check_en || (acc_fin == pbits);
  assign q_push   = take && (p == PARITY_POS) && (fnum <= FRAME_MAX);
  assign gcnt_next = (good && gcnt != COUNT_MAX) ? gcnt + 16'd1 : gcnt;

  always_comb begin
    q_desc.frame_number = fnum;
    q_desc.frame_good   = good;
    q_desc.good_count   = gcnt_next;
    q_desc.subcom       = subcom;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= 7'd0;
      acc      <= 6'd0;
      fnum     <= 9'd0;
      gcnt     <= 16'd0;
      check_en <= 1'b1;
    end else begin
      if (parity_check_enable_we) check_en <= parity_check_enable;
      if (take) begin
        pos <= p + 7'd1;
        acc <= (p == PARITY_POS) ? acc_fin : acc_next;
        if (p == FNUM_HI_POS) fnum[8]   <= frame_byte[0];
        if (p == FNUM_LO_POS) fnum[7:0] <= frame_byte;
      end
      if (q_push) gcnt <= gcnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && p >= SUBCOM_FIRST && p <= SUBCOM_LAST) subcom[p[2:0]] <= frame_byte;
  end

endmodule
`default_nettype wire

FILE: sv/tfp_queue.sv
// two-entry frame descriptor queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module tfp_queue import tfp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  wr,
  input  wire frame_desc_t wr_desc,
  output logic       q_full,
  input  wire logic  rd,
  output logic       q_empty,
  output frame_desc_t rd_desc
);

  frame_desc_t entry [2];
  logic        wptr, rptr;
  logic [1:0]  count;

  assign q_full  = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign rd_desc = entry[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wptr <= !wptr;
      if (rd) rptr <= !rptr;
      if (wr && !rd)      count <= count + 2'd1;
      else if (rd && !wr) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) entry[wptr] <= wr_desc;
  end

endmodule
`default_nettype wire

FILE: sv/tfp_back.sv
// back end: expands one frame descriptor into eight channel items
`timescale 1ns / 1ps
`default_nettype none
module tfp_back import tfp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_empty,
  output logic       q_pop,
  input  wire frame_desc_t q_desc,
  output logic       empty,
  input  wire logic  pop,
  output logic [2:0] channel,
  output logic [8:0] slot,
  output logic [7:0] value,
  output logic [8:0] frame_number,
  output logic       frame_good,
  output logic       row_start,
  output logic [15:0] good_count,
  output logic       last
);

  frame_desc_t desc;
  logic        busy;
  logic [2:0]  idx;
  logic        ov;

  logic        out_free;
  logic [16:0] prod;
  logic [5:0]  quo;
  logic [8:0]  m10, m160, slot_c;

  assign empty    = !ov;
  assign out_free = !ov || pop;
  assign q_pop    = !busy && !q_empty;

  // mod 10 by reciprocal, exact for frame numbers below 320
  assign prod = {8'd0, desc.frame_number} * RECIP10;
  assign quo  = prod[RECIP10_SHIFT +: 6];
  assign m10  = desc.frame_number - ({3'd0, quo} * {3'd0, TEN});
  assign m160 = (desc.frame_number >= HALF_ROW) ? desc.frame_number - HALF_ROW
                                                : desc.frame_number;

  always_comb begin
    case (idx)
      CH_ANALOG32S:                        slot_c = desc.frame_number;
      CH_ANALOG16S, CH_ANALOG16S_B:        slot_c = m160;
      CH_DIGITAL1, CH_DIGITAL2:            slot_c = {1'b0, desc.frame_number[4:0], 3'd0};
      CH_ANALOG1S, CH_DAU1, CH_DAU2:       slot_c = m10;
      default:                             slot_c = m10;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 3'd0;
      ov   <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
        idx  <= 3'd0;
      end
      if (out_free) ov <= busy;
      if (busy && out_free) begin
        idx <= idx + 3'd1;
        if (idx == CH_DAU2) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) desc <= q_desc;
    if (busy && out_free) begin
      channel      <= idx;
      slot         <= slot_c;
      value        <= desc.frame_good ? desc.subcom[subcom_index(idx)] : 8'd0;
      frame_number <= desc.frame_number;
      frame_good   <= desc.frame_good;
      row_start    <= (slot_c == 9'd0);
      good_count   <= desc.good_count;
      last         <= (idx == CH_DAU2);
    end
  end

endmodule
`default_nettype wire

FILE: sv/tip_frame_parity_subcom_demux.sv
// top level: minor frame parity check and subcommutated channel demux
//
//   channel   direction  handshake     payload
//   bytes     in         push / full   frame_byte, frame_start
//   results   out        pop / empty   channel, slot, value, frame_number,
//                                      frame_good, row_start, good_count, last
//   config    in         _we           parity_check_enable
//
// one byte is taken every cycle while full is low; full rises only when the
// two-entry frame queue is full and the back end is stalled by the sink.
// each frame numbered 0..319 yields eight items, one per cycle while pop is high,
// from the output register; a gap follows each frame while the back end reloads.
// items pass queue entry, descriptor register and output register in that order.
// synchronous reset clears position, parity, count and queues; check enable = 1.
`timescale 1ns / 1ps
`default_nettype none
module tip_frame_parity_subcom_demux import tfp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        parity_check_enable_we,
  input  wire logic        parity_check_enable,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  frame_byte,
  input  wire logic        frame_start,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       channel,
  output logic [8:0]       slot,
  output logic [7:0]       value,
  output logic [8:0]       frame_number,
  output logic             frame_good,
  output logic             row_start,
  output logic [15:0]      good_count,
  output logic             last
);

  frame_desc_t wr_desc, rd_desc;
  logic        q_push, q_full, q_pop, q_empty;

  tfp_front u_front (
    .clk(clk), .rst(rst),
    .parity_check_enable_we(parity_check_enable_we),
    .parity_check_enable(parity_check_enable),
    .push(push), .full(full),
    .frame_byte(frame_byte), .frame_start(frame_start),
    .q_full(q_full), .q_push(q_push), .q_desc(wr_desc)
  );

  tfp_queue u_queue (
    .clk(clk), .rst(rst),
    .wr(q_push), .wr_desc(wr_desc), .q_full(q_full),
    .rd(q_pop), .q_empty(q_empty), .rd_desc(rd_desc)
  );

  tfp_back u_back (
    .clk(clk), .rst(rst),
    .q_empty(q_empty), .q_pop(q_pop), .q_desc(rd_desc),
    .empty(empty), .pop(pop),
    .channel(channel), .slot(slot), .value(value),
    .frame_number(frame_number), .frame_good(frame_good),
    .row_start(row_start), .good_count(good_count), .last(last)
  );

endmodule
`default_nettype wire

FILE: sv/tfp_checker.sv
// port-level checks on the result channel, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module tfp_checker import tfp_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [2:0]  channel,
  input wire logic [7:0]  value,
  input wire logic [8:0]  frame_number,
  input wire logic        frame_good,
  input wire logic [15:0] good_count,
  input wire logic        last
);

  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (last == (channel == CH_DAU2)))
    else $error("last flag does not match final channel");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !frame_good) |-> (value == 8'd0))
    else $error("bad frame item carries nonzero value");

  a_channel_seq: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last) |=> (!empty && channel == $past(channel) + 3'd1))
    else $error("frame items not back to back in channel order");

  a_frame_fields: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last) |=>
      (frame_number == $past(frame_number) && good_count == $past(good_count)))
    else $error("frame fields change within a frame");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> empty)
    else $error("result queue not empty after reset");

endmodule

bind tip_frame_parity_subcom_demux tfp_checker u_checker (
  .clk(clk), .rst(rst), .empty(empty), .pop(pop), .channel(channel),
  .value(value), .frame_number(frame_number), .frame_good(frame_good),
  .good_count(good_count), .last(last)
);
`default_nettype wire
